// ----- hw/rtl/bpc_pkg.sv -----
package bpc_pkg;

  localparam int TIME_BITS_DEFAULT = 32;
  localparam int NOW_WIDTH         = 32;
  localparam int CFG_WIDTH         = 16;
  localparam int CFG_INDEX_WIDTH   = 2;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_MS_RESET   = 16'd50;
  localparam logic [CFG_WIDTH-1:0] DOUBLE_GAP_MS_RESET = 16'd250;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_MS_RESET = 16'd800;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_DEBOUNCE_MS   = 2'd0,
    REG_DOUBLE_GAP_MS = 2'd1,
    REG_LONG_PRESS_MS = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } press_event_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] double_gap_ms;
    logic [CFG_WIDTH-1:0] long_press_ms;
  } class_cfg_t;

endpackage

// ----- hw/rtl/bpc_sample_if.sv -----
interface bpc_sample_if;
  logic                           valid;
  logic                           ready;
  logic                           raw_level;
  logic [bpc_pkg::NOW_WIDTH-1:0]  now_ms;

  modport source (output valid, output raw_level, output now_ms, input ready);
  modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

// ----- hw/rtl/bpc_result_if.sv -----
interface bpc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_event;
  logic       clean_level;

  modport source (output valid, output press_event, output clean_level, input ready);
  modport sink   (input valid, input press_event, input clean_level, output ready);
endinterface

// ----- hw/rtl/bpc_cfg_if.sv -----
interface bpc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [bpc_pkg::CFG_INDEX_WIDTH-1:0]  index;
  logic [bpc_pkg::CFG_WIDTH-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/bpc_debounce.sv -----
module bpc_debounce #(
  parameter int TIME_BITS = bpc_pkg::TIME_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           raw_level,
  input  logic [TIME_BITS-1:0]           now,
  input  logic [bpc_pkg::CFG_WIDTH-1:0]  debounce_ms,
  output logic                           level_next
);
  import bpc_pkg::*;

  logic                 previous_raw;
  logic                 debounced_level;
  logic [TIME_BITS-1:0] raw_change_time;
  logic [TIME_BITS-1:0] elapsed;
  logic                 raw_edge;

  assign raw_edge = raw_level != previous_raw;
  assign elapsed  = now - raw_change_time;

  // on a raw edge the change time becomes now, so the level holds as if the elapsed time were zero
  always_comb begin
    level_next = debounced_level;
    if (!raw_edge && (elapsed > TIME_BITS'(debounce_ms))) begin
      level_next = raw_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw    <= 1'b0;
      debounced_level <= 1'b0;
      raw_change_time <= '0;
    end else if (accept) begin
      previous_raw    <= raw_level;
      debounced_level <= level_next;
      if (raw_edge) begin
        raw_change_time <= now;
      end
    end
  end

endmodule

// ----- hw/rtl/bpc_queue.sv -----
module bpc_queue #(
  parameter int WIDTH = bpc_pkg::TIME_BITS_DEFAULT + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             not_empty,
  output logic             not_full
);
  import bpc_pkg::*;

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign head      = mem[rd_ptr];
  assign not_empty = count != 2'd0;
  assign not_full  = count != 2'd2;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/bpc_classify.sv -----
module bpc_classify #(
  parameter int TIME_BITS = bpc_pkg::TIME_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 cur,
  input  logic [TIME_BITS-1:0] now,
  input  bpc_pkg::class_cfg_t  cfg,
  output logic                 take,
  bpc_result_if.source         result
);
  import bpc_pkg::*;

  logic                 previous_debounced;
  logic [TIME_BITS-1:0] press_start_time;
  logic [TIME_BITS-1:0] release_time;
  logic                 click_pending;
  logic                 long_already_fired;

  logic                 click_pending_next;
  logic                 long_already_fired_next;
  logic                 set_press_start;
  logic                 set_release;
  press_event_t         ev;

  logic [TIME_BITS-1:0] since_release;
  logic [TIME_BITS-1:0] since_press;
  logic                 within_gap;

  logic                 out_valid;
  press_event_t         out_event;
  logic                 out_level;

  assign since_release = now - release_time;
  assign since_press   = now - press_start_time;
  assign within_gap    = since_release <= TIME_BITS'(cfg.double_gap_ms);

  // output register frees when empty or being taken this cycle
  assign take = item_valid && (!out_valid || result.ready);

  always_comb begin
    ev                      = EV_NONE;
    click_pending_next      = click_pending;
    long_already_fired_next = long_already_fired;
    set_press_start         = 1'b0;
    set_release             = 1'b0;
    case ({cur, previous_debounced})
      2'b10: begin
        set_press_start         = 1'b1;
        long_already_fired_next = 1'b0;
      end
      2'b01: begin
        // a release that ends a long press counts no click
        if (!long_already_fired) begin
          if (click_pending && within_gap) begin
            ev                 = EV_DOUBLE;
            click_pending_next = 1'b0;
          end else begin
            click_pending_next = 1'b1;
            set_release        = 1'b1;
          end
        end
      end
      2'b11: begin
        if (!long_already_fired && (since_press >= TIME_BITS'(cfg.long_press_ms))) begin
          ev                      = EV_LONG;
          long_already_fired_next = 1'b1;
          click_pending_next      = 1'b0;
        end
      end
      default: begin
        if (click_pending && !within_gap) begin
          ev                 = EV_SINGLE;
          click_pending_next = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_debounced <= 1'b0;
      click_pending      <= 1'b0;
      long_already_fired <= 1'b0;
      press_start_time   <= '0;
      release_time       <= '0;
    end else if (take) begin
      previous_debounced <= cur;
      click_pending      <= click_pending_next;
      long_already_fired <= long_already_fired_next;
      if (set_press_start) begin
        press_start_time <= now;
      end
      if (set_release) begin
        release_time <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_event <= ev;
      out_level <= cur;
    end
  end

  assign result.valid       = out_valid;
  assign result.press_event = out_event;
  assign result.clean_level = out_level;

endmodule

// ----- hw/rtl/button_press_classifier_top.sv -----
// Debounces a sampled button level and classifies presses as single, double
// or long. One sample is taken per clock cycle while the queue has room; a
// sample passes from the debounce front end through the two-entry queue to
// the classifier and then into the output register. The front end keeps
// accepting while the two-entry queue has room, so a stalled result port
// holds off the input only after the queue and the output register have
// filled. Timestamps are compared modulo 2^TIME_BITS; the 32-bit now_ms is
// zero-extended or truncated to that width. Settings are written through the
// cfg port (0 debounce, 1 double-click gap, 2 long-press time, all in ms, 16
// bits); the user must write them only while the block is idle, which the
// block itself does not enforce; other indexes are ignored.
module button_press_classifier_top #(
  parameter int TIME_BITS = bpc_pkg::TIME_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  bpc_sample_if.sink   sample,
  bpc_result_if.source result,
  bpc_cfg_if.sink      cfg
);
  import bpc_pkg::*;

  logic [CFG_WIDTH-1:0] debounce_ms;
  logic [CFG_WIDTH-1:0] double_gap_ms;
  logic [CFG_WIDTH-1:0] long_press_ms;
  class_cfg_t           class_cfg;

  logic [63:0]          now_wide;
  logic [TIME_BITS-1:0] now;
  logic                 accept;
  logic                 level_next;
  logic                 q_not_full;
  logic                 q_not_empty;
  logic                 q_pop;
  logic [TIME_BITS:0]   q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= DEBOUNCE_MS_RESET;
      double_gap_ms <= DOUBLE_GAP_MS_RESET;
      long_press_ms <= LONG_PRESS_MS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DEBOUNCE_MS:   debounce_ms   <= cfg.data;
        REG_DOUBLE_GAP_MS: double_gap_ms <= cfg.data;
        REG_LONG_PRESS_MS: long_press_ms <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  assign class_cfg.double_gap_ms = double_gap_ms;
  assign class_cfg.long_press_ms = long_press_ms;

  assign now_wide     = {32'd0, sample.now_ms};
  assign now          = now_wide[TIME_BITS-1:0];
  assign sample.ready = q_not_full;
  assign accept       = sample.valid && q_not_full;

  bpc_debounce #(
    .TIME_BITS (TIME_BITS)
  ) u_debounce (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .raw_level   (sample.raw_level),
    .now         (now),
    .debounce_ms (debounce_ms),
    .level_next  (level_next)
  );

  bpc_queue #(
    .WIDTH (TIME_BITS + 1)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data ({level_next, now}),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  bpc_classify #(
    .TIME_BITS (TIME_BITS)
  ) u_classify (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_not_empty),
    .cur        (q_head[TIME_BITS]),
    .now        (q_head[TIME_BITS-1:0]),
    .cfg        (class_cfg),
    .take       (q_pop),
    .result     (result)
  );

endmodule

// ----- verif/button_press_classifier_checker.sv -----
`timescale 1ns / 1ps
module button_press_classifier_checker
  import bpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  bpc_sample_if smp,
  bpc_result_if rslt,
  bpc_cfg_if    cfg,
  output int    mismatches,
  output int    outstanding,
  output int    seen,
  output int    singles,
  output int    longs,
  output int    doubles
);

  typedef struct packed {
    press_event_t ev;
    logic         lvl;
  } outcome_t;

  outcome_t outcome_q [$];

  logic [CFG_WIDTH-1:0] settle_ms;
  logic [CFG_WIDTH-1:0] gap_ms;
  logic [CFG_WIDTH-1:0] hold_ms;

  logic [NOW_WIDTH-1:0] edge_stamp;
  logic [NOW_WIDTH-1:0] press_stamp;
  logic [NOW_WIDTH-1:0] release_stamp;
  logic                 level;
  logic                 last_raw;
  logic                 last_level;
  logic                 click_wait;
  logic                 long_done;

  int n_bad;
  int n_seen;
  int tally [4];

  function automatic outcome_t classify_sample(input logic raw, input logic [NOW_WIDTH-1:0] now);
    outcome_t o;
    o.ev = EV_NONE;
    if (raw != last_raw)
      edge_stamp = now;
    if ((now - edge_stamp) > settle_ms)
      level = raw;
    last_raw = raw;

    if (level && !last_level) begin
      press_stamp = now;
      long_done   = 1'b0;
    end else if (!level && last_level) begin
      // a release that ends a long press is not a click
      if (!long_done) begin
        if (click_wait && (now - release_stamp) <= gap_ms) begin
          o.ev       = EV_DOUBLE;
          click_wait = 1'b0;
        end else begin
          click_wait    = 1'b1;
          release_stamp = now;
        end
      end
    end else if (level && last_level) begin
      if (!long_done && (now - press_stamp) >= hold_ms) begin
        o.ev       = EV_LONG;
        long_done  = 1'b1;
        click_wait = 1'b0;
      end
    end else if (click_wait && (now - release_stamp) > gap_ms) begin
      o.ev       = EV_SINGLE;
      click_wait = 1'b0;
    end
    last_level = level;
    o.lvl = level;
    return o;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      outcome_q.delete();
      settle_ms     = DEBOUNCE_MS_RESET;
      gap_ms        = DOUBLE_GAP_MS_RESET;
      hold_ms       = LONG_PRESS_MS_RESET;
      edge_stamp    = '0;
      press_stamp   = '0;
      release_stamp = '0;
      level         = 1'b0;
      last_raw      = 1'b0;
      last_level    = 1'b0;
      click_wait    = 1'b0;
      long_done     = 1'b0;
      n_bad         = 0;
      n_seen        = 0;
      foreach (tally[i]) tally[i] = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_DEBOUNCE_MS:   settle_ms = cfg.data;
          REG_DOUBLE_GAP_MS: gap_ms    = cfg.data;
          REG_LONG_PRESS_MS: hold_ms   = cfg.data;
          default: ;
        endcase
      end
      // push before pop so a same-edge result never finds an empty store
      if (smp.valid && smp.ready)
        outcome_q.push_back(classify_sample(smp.raw_level, smp.now_ms));
      if (rslt.valid && rslt.ready) begin
        if (outcome_q.size() == 0) begin
          n_bad++;
          $error("result with none expected: press_event %0d clean_level %0d",
                 rslt.press_event, rslt.clean_level);
        end else begin
          want = outcome_q.pop_front();
          if (rslt.press_event !== want.ev) begin
            n_bad++;
            $error("press_event: expected %0d, got %0d", want.ev, rslt.press_event);
          end
          if (rslt.clean_level !== want.lvl) begin
            n_bad++;
            $error("clean_level: expected %0d, got %0d", want.lvl, rslt.clean_level);
          end
          tally[want.ev]++;
          n_seen++;
        end
      end
    end
    mismatches  <= n_bad;
    outstanding <= outcome_q.size();
    seen        <= n_seen;
    singles     <= tally[EV_SINGLE];
    longs       <= tally[EV_LONG];
    doubles     <= tally[EV_DOUBLE];
  end

endmodule

// ----- verif/button_press_classifier_top_test.sv -----
`timescale 1ns / 1ps
module button_press_classifier_top_test;
  import bpc_pkg::*;

  // index outside the register map; writes to it must be dropped
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

  logic clk;
  logic rst;

  bpc_sample_if sample_ch ();
  bpc_result_if result_ch ();
  bpc_cfg_if    cfg_ch ();

  int mismatches;
  int outstanding;
  int seen;
  int singles;
  int longs;
  int doubles;

  button_press_classifier_top dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  button_press_classifier_checker watcher (
    .clk         (clk),
    .rst         (rst),
    .smp         (sample_ch),
    .rslt        (result_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .seen        (seen),
    .singles     (singles),
    .longs       (longs),
    .doubles     (doubles)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  int                   sent    = 0;
  int                   phases  = 1;
  bit                   calm    = 1'b0;
  bit                   idle_on = 1'b0;
  logic [NOW_WIDTH-1:0] stamp;
  int unsigned          db_ms;
  int unsigned          gap_ms;
  int unsigned          lp_ms;

  // {raw_level, now_ms} at reset timing: debounce edge, long press, release
  // after long, double press, single press on gap expiry
  logic [32:0] opening [25] = '{
    {1'b0, 32'd0},    {1'b1, 32'd10},   {1'b0, 32'd20},   {1'b1, 32'd30},
    {1'b1, 32'd80},   {1'b1, 32'd81},   {1'b1, 32'd880},  {1'b1, 32'd881},
    {1'b1, 32'd2000}, {1'b0, 32'd2001}, {1'b0, 32'd2052}, {1'b1, 32'd2100},
    {1'b1, 32'd2151}, {1'b0, 32'd2160}, {1'b0, 32'd2211}, {1'b1, 32'd2220},
    {1'b1, 32'd2271}, {1'b0, 32'd2280}, {1'b0, 32'd2331}, {1'b1, 32'd2400},
    {1'b1, 32'd2451}, {1'b0, 32'd2460}, {1'b0, 32'd2511}, {1'b0, 32'd2761},
    {1'b0, 32'd2762}
  };

  task automatic put_sample(input logic lvl, input logic [NOW_WIDTH-1:0] t);
    if (sent % 100 == 0)
      idle_on = !calm && ($urandom_range(0, 3) != 0);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.raw_level <= lvl;
    sample_ch.now_ms    <= t;
    do @(posedge clk); while (!sample_ch.ready);
    sent++;
  endtask

  task automatic put_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic hold_for(input logic lvl, input int unsigned span);
    int unsigned step_max;
    int unsigned walked;
    int unsigned step;
    step_max = span / 6 + 1;
    walked   = 0;
    while (walked <= span) begin
      put_sample(lvl, stamp);
      step   = $urandom_range(1, step_max);
      stamp  += step;
      walked += step;
    end
  endtask

  task automatic chatter(input int n);
    repeat (n) begin
      put_sample(1'($urandom_range(0, 1)), stamp);
      stamp += $urandom_range(1, db_ms / 3 + 1);
    end
  endtask

  task automatic noise(input int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        stamp = $urandom;
      else
        stamp += $urandom_range(0, db_ms + 2);
      put_sample(1'($urandom_range(0, 1)), stamp);
    end
  endtask

  task automatic press_cycle();
    int unsigned hold;
    int unsigned rest;
    case ($urandom_range(0, 2))
      0:       hold = db_ms + $urandom_range(0, gap_ms / 3 + 2);
      1:       hold = db_ms + $urandom_range(0, lp_ms + 2);
      default: hold = db_ms + lp_ms + $urandom_range(0, lp_ms / 2 + 5);
    endcase
    if ($urandom_range(0, 1))
      rest = db_ms + $urandom_range(0, gap_ms / 3 + 2);
    else
      rest = db_ms + gap_ms + $urandom_range(0, gap_ms / 2 + 5);
    chatter($urandom_range(0, 4));
    hold_for(1'b1, hold);
    chatter($urandom_range(0, 4));
    hold_for(1'b0, rest);
  endtask

  task automatic run_phase(input logic [CFG_WIDTH-1:0] db, input logic [CFG_WIDTH-1:0] gap,
                           input logic [CFG_WIDTH-1:0] lp, input int n);
    int goal;
    drain();
    put_reg(REG_DEBOUNCE_MS, db);
    put_reg(REG_DOUBLE_GAP_MS, gap);
    put_reg(REG_LONG_PRESS_MS, lp);
    put_reg(REG_SPARE, CFG_WIDTH'($urandom));
    cfg_ch.valid <= 1'b0;
    db_ms  = 32'(db);
    gap_ms = 32'(gap);
    lp_ms  = 32'(lp);
    phases++;
    case ($urandom_range(0, 2))
      0: stamp = $urandom;
      // start just short of the wrap so it lands mid-phase
      1: stamp = 32'hFFFF_FFFF - $urandom_range(0, 3 * (db_ms + gap_ms + lp_ms) + 100);
      default: ;
    endcase
    goal = sent + n;
    while (sent < goal) begin
      if ($urandom_range(0, 6) != 0)
        press_cycle();
      else
        noise($urandom_range(1, 6));
    end
  endtask

  // result side back-pressure
  initial begin
    int unsigned stall_left;
    stall_left      = 0;
    result_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        if (stall_left == 0)
          result_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 19);
        result_ch.ready <= 1'b0;
      end
    end
  end

  initial begin
    rst                 = 1'b1;
    sample_ch.valid     = 1'b0;
    sample_ch.raw_level = 1'b0;
    sample_ch.now_ms    = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_DEBOUNCE_MS;
    cfg_ch.data         = '0;
    stamp               = '0;
    db_ms               = 32'(DEBOUNCE_MS_RESET);
    gap_ms              = 32'(DOUBLE_GAP_MS_RESET);
    lp_ms               = 32'(LONG_PRESS_MS_RESET);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) put_sample(opening[i][32], opening[i][31:0]);
    stamp = 32'd2800;

    run_phase(16'd0, 16'd0, 16'd0, 150);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 150);
    repeat (5) begin
      if ($urandom_range(0, 1))
        run_phase(CFG_WIDTH'($urandom_range(0, 12)), CFG_WIDTH'($urandom_range(0, 40)),
                  CFG_WIDTH'($urandom_range(0, 80)), 220);
      else
        run_phase(CFG_WIDTH'($urandom_range(0, 200)), CFG_WIDTH'($urandom_range(0, 1500)),
                  CFG_WIDTH'($urandom_range(0, 3000)), 220);
    end
    calm    = 1'b1;
    idle_on = 1'b0;
    run_phase(DEBOUNCE_MS_RESET, DOUBLE_GAP_MS_RESET, LONG_PRESS_MS_RESET, 250);
    drain();
    repeat (6) @(posedge clk);

    $display("Drove %0d samples across %0d timing settings, zero and full scale included.",
             sent, phases);
    $display("Checked %0d results: %0d single, %0d long and %0d double presses.",
             seen, singles, longs, doubles);
    if (mismatches == 0 && outstanding == 0)
      $display("button_press_classifier_top_test: PASS");
    else
      $display("button_press_classifier_top_test: FAIL");
    $finish;
  end

  initial begin
    #600_000;
    $display("button_press_classifier_top_test: FAIL");
    $finish;
  end

endmodule
